/* hdl/fdbm_pkg.sv */
// fdbm_pkg: shared constants, register codes and color type of the fragment merger
// no dependencies; imported by fdbm_blend and fragment_depth_blend_merge
`default_nettype none

package fdbm_pkg;

  // storage geometry
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned DEPTH_BITS = 24;
  localparam int unsigned STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(STORE_SIZE);

  // field widths
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned FRAG_Z_W   = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 4 * CHAN_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // depth value of a cleared entry (far plane)
  localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = {DEPTH_BITS{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TEST_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FUNC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_EN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

  // depth compare functions, other codes never pass
  localparam logic [1:0] DFUNC_LESS    = 2'd0;
  localparam logic [1:0] DFUNC_GREATER = 2'd1;

  // color store entry, red in the high byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

endpackage

`default_nettype wire

/* hdl/fdbm_ram.sv */
// fdbm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; a read of the address being written returns the old data
`default_nettype none

module fdbm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/fdbm_blend.sv */
// fdbm_blend: source-over blend of three color channels by source alpha
// depends on fdbm_pkg for the rgba_t type and channel width
`default_nettype none

module fdbm_blend import fdbm_pkg::*; (
  input  wire logic  [CHAN_W-1:0] src_red,
  input  wire logic  [CHAN_W-1:0] src_green,
  input  wire logic  [CHAN_W-1:0] src_blue,
  input  wire logic  [CHAN_W-1:0] src_alpha,
  input  wire rgba_t              dst,
  output rgba_t                   mixed
);

  // (s*a + d*(255-a)) / 255, the divide done as (v + (v >> 8) + 1) >> 8
  function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] s,
                                            input logic [CHAN_W-1:0] d,
                                            input logic [CHAN_W-1:0] a);
    logic [CHAN_W-1:0]   na;
    logic [2*CHAN_W-1:0] v;
    logic [2*CHAN_W:0]   q;
    // 255 - a, kept at channel width
    na = ~a;
    v  = s * a + d * na;
    q  = {1'b0, v} + {{(CHAN_W+1){1'b0}}, v[2*CHAN_W-1:CHAN_W]} + 1'b1;
    return q[2*CHAN_W-1:CHAN_W];
  endfunction

  // per channel mix, stored alpha becomes opaque
  always_comb begin
    mixed.red   = mix(src_red,   dst.red,   src_alpha);
    mixed.green = mix(src_green, dst.green, src_alpha);
    mixed.blue  = mix(src_blue,  dst.blue,  src_alpha);
    mixed.alpha = {CHAN_W{1'b1}};
  end

endmodule

`default_nettype wire

/* hdl/fragment_depth_blend_merge.sv */
// fragment_depth_blend_merge: an accepted request passes the stage 1 register and the
// output register to its result at out_*, one fragment per cycle while out_stall is low;
// the depth and color rams are read at accept and written back when stage 1 moves on,
// with the last write forwarded; reset: after rst_n, a clearing pass writes far depth and
// zero color to all STORE_SIZE (262144) entries; in_stall stays high during it, cfg writes are taken
// depends on fdbm_pkg, fdbm_ram and fdbm_blend
`default_nettype none

module fragment_depth_blend_merge import fdbm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // fragment input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_W-1:0]    in_pixel_x,
  input  wire logic [COORD_W-1:0]    in_pixel_y,
  input  wire logic [FRAG_Z_W-1:0]   in_frag_depth,
  input  wire logic [CHAN_W-1:0]     in_src_red,
  input  wire logic [CHAN_W-1:0]     in_src_green,
  input  wire logic [CHAN_W-1:0]     in_src_blue,
  input  wire logic [CHAN_W-1:0]     in_src_alpha,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_pixel_written,
  output logic                       out_outside_frame,
  output logic [CHAN_W-1:0]          out_final_red,
  output logic [CHAN_W-1:0]          out_final_green,
  output logic [CHAN_W-1:0]          out_final_blue,
  output logic [CHAN_W-1:0]          out_final_alpha,
  // configuration write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                  depth_test_en_r;
  logic [1:0]            depth_func_r;
  logic                  blend_en_r;
  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // stage 1 (ram data valid)
  logic                  s1_valid_r;
  logic                  s1_inside_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [DEPTH_BITS-1:0] s1_z_r;
  rgba_t                 s1_src_r;

  // forwarding of the last ram writes
  logic                  dfwd_valid_r;
  logic [ADDR_W-1:0]     dfwd_addr_r;
  logic [DEPTH_BITS-1:0] dfwd_data_r;
  logic                  cfwd_valid_r;
  logic [ADDR_W-1:0]     cfwd_addr_r;
  rgba_t                 cfwd_data_r;

  // output register
  logic        out_valid_r;
  logic        out_pixel_written_r;
  logic        out_outside_frame_r;
  rgba_t       out_color_r;

  logic                  in_accept;
  logic                  s1_adv;
  logic [COORD_W:0]      width_eff;
  logic [COORD_W:0]      height_eff;
  logic                  in_inside;
  logic [2*COORD_W-1:0]  addr_full;
  logic [ADDR_W-1:0]     in_addr;
  logic [DEPTH_BITS-1:0] depth_rdata;
  logic [COLOR_W-1:0]    color_rdata;
  logic [DEPTH_BITS-1:0] old_depth;
  rgba_t                 stored_color;
  rgba_t                 mixed_color;
  rgba_t                 new_color;
  logic                  depth_pass;
  logic                  s1_written;
  logic                  depth_we;
  logic                  color_we;
  logic                  dram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DEPTH_BITS-1:0] dram_wdata;
  logic                  cram_we;
  rgba_t                 cram_wdata;
  logic                  out_valid_nxt;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clearing_r || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  // configuration writes, value masked by port width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_test_en_r <= 1'b0;
      depth_func_r    <= DFUNC_LESS;
      blend_en_r      <= 1'b0;
      frame_width_r   <= CFG_DATA_W'(MAX_WIDTH);
      frame_height_r  <= CFG_DATA_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEPTH_TEST_EN: depth_test_en_r <= cfg_data[0];
        CFG_DEPTH_FUNC:    depth_func_r    <= cfg_data[1:0];
        CFG_BLEND_EN:      blend_en_r      <= cfg_data[0];
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass over both stores after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == ADDR_W'(STORE_SIZE - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // frame bounds clamped to the storage size
  assign width_eff  = ({1'b0, frame_width_r} > (COORD_W + 1)'(MAX_WIDTH)) ?
                      (COORD_W + 1)'(MAX_WIDTH) : {1'b0, frame_width_r};
  assign height_eff = ({1'b0, frame_height_r} > (COORD_W + 1)'(MAX_HEIGHT)) ?
                      (COORD_W + 1)'(MAX_HEIGHT) : {1'b0, frame_height_r};
  assign in_inside  = ({1'b0, in_pixel_x} < width_eff) && ({1'b0, in_pixel_y} < height_eff);

  // store address y * MAX_WIDTH + x
  assign addr_full = {{COORD_W{1'b0}}, in_pixel_y} * (2 * COORD_W)'(MAX_WIDTH)
                   + {{COORD_W{1'b0}}, in_pixel_x};
  assign in_addr   = addr_full[ADDR_W-1:0];

  // stage 1 request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_inside_r <= in_inside;
      s1_addr_r   <= in_addr;
      s1_z_r      <= in_frag_depth[DEPTH_BITS-1:0];
      s1_src_r    <= '{red: in_src_red, green: in_src_green,
                       blue: in_src_blue, alpha: in_src_alpha};
    end
  end

  // stores: read at accept, written when stage 1 moves on
  assign dram_we    = clearing_r || depth_we;
  assign cram_we    = clearing_r || color_we;
  assign ram_waddr  = clearing_r ? clr_addr_r : s1_addr_r;
  assign dram_wdata = clearing_r ? DEPTH_FAR : s1_z_r;
  assign cram_wdata = clearing_r ? rgba_t'('0) : new_color;

  fdbm_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (STORE_SIZE)
  ) u_depth_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (ram_waddr),
    .wdata (dram_wdata),
    .re    (in_accept && in_inside),
    .raddr (in_addr),
    .rdata (depth_rdata)
  );

  fdbm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_SIZE)
  ) u_color_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (ram_waddr),
    .wdata (cram_wdata),
    .re    (in_accept && in_inside),
    .raddr (in_addr),
    .rdata (color_rdata)
  );

  // forward the write that landed together with this request's read
  assign old_depth    = (dfwd_valid_r && dfwd_addr_r == s1_addr_r) ? dfwd_data_r :
                        depth_rdata;
  assign stored_color = (cfwd_valid_r && cfwd_addr_r == s1_addr_r) ? cfwd_data_r :
                        rgba_t'(color_rdata);

  // depth test
  always_comb begin
    priority if (!depth_test_en_r) begin
      depth_pass = 1'b1;
    end else if (depth_func_r == DFUNC_LESS) begin
      depth_pass = s1_z_r < old_depth;
    end else if (depth_func_r == DFUNC_GREATER) begin
      depth_pass = s1_z_r > old_depth;
    end else begin
      depth_pass = 1'b0;
    end
  end

  assign s1_written = s1_inside_r && depth_pass;
  assign depth_we   = s1_adv && s1_written && depth_test_en_r;
  assign color_we   = s1_adv && s1_written;

  // blend
  fdbm_blend u_blend (
    .src_red   (s1_src_r.red),
    .src_green (s1_src_r.green),
    .src_blue  (s1_src_r.blue),
    .src_alpha (s1_src_r.alpha),
    .dst       (stored_color),
    .mixed     (mixed_color)
  );

  assign new_color = blend_en_r ? mixed_color : s1_src_r;

  // last write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfwd_valid_r <= 1'b0;
      cfwd_valid_r <= 1'b0;
    end else begin
      if (depth_we) begin
        dfwd_valid_r <= 1'b1;
      end
      if (color_we) begin
        cfwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      dfwd_addr_r <= s1_addr_r;
      dfwd_data_r <= s1_z_r;
    end
    if (color_we) begin
      cfwd_addr_r <= s1_addr_r;
      cfwd_data_r <= new_color;
    end
  end

  // output register
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_written_r <= s1_written;
      out_outside_frame_r <= !s1_inside_r;
      out_color_r         <= s1_written ? new_color : rgba_t'('0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_written = out_pixel_written_r;
  assign out_outside_frame = out_outside_frame_r;
  assign out_final_red     = out_color_r.red;
  assign out_final_green   = out_color_r.green;
  assign out_final_blue    = out_color_r.blue;
  assign out_final_alpha   = out_color_r.alpha;

  // a depth write always comes with a color write
  a_depth_with_color: assert property (@(posedge clk) disable iff (!rst_n)
    depth_we |-> color_we)
    else $error("depth written without color");

  // an accepted request is in stage 1 the next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted request lost");

  // clearing ends only after the last entry
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_addr_r) == ADDR_W'(STORE_SIZE - 1))
    else $error("clearing pass ended early");

  // a result that was not written carries zero color
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pixel_written_r) |-> out_color_r == rgba_t'('0))
    else $error("unwritten result with nonzero color");

endmodule

`default_nettype wire
